FILE: src/quantized_average_pool_accumulate_macros.svh
// assertion helpers for the average pool accumulator
`ifndef QUANTIZED_AVERAGE_POOL_ACCUMULATE_MACROS_SVH
`define QUANTIZED_AVERAGE_POOL_ACCUMULATE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define QAPA_ASSERT_NOW(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("qapa check failed");

// next-cycle implication, disabled while reset is held
`define QAPA_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("qapa check failed");

`endif

FILE: src/qapa_pkg.sv
package qapa_pkg;

    localparam int BYTE_W      = 8;
    localparam int ACC_W       = 32;
    localparam int SCALE_W     = 32;
    localparam int FRAC_W      = 24;
    localparam int PROD_W      = ACC_W + SCALE_W;
    localparam int QUOT_W      = PROD_W - FRAC_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CHAN_CNT    = 1 << BYTE_W;

    // output queue sizing
    localparam int OUT_Q_DEPTH = 8;
    localparam int OUT_Q_PTR_W = 3;
    localparam int OUT_Q_CNT_W = 4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACC_BIAS   = 3'd0,
        CFG_SCALE      = 3'd1,
        CFG_ZERO_POINT = 3'd2,
        CFG_OUT_MIN    = 3'd3,
        CFG_OUT_MAX    = 3'd4
    } t_cfg_idx;

    localparam logic [ACC_W-1:0]   BIAS_RESET  = '0;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;
    localparam logic [BYTE_W-1:0]  ZP_RESET    = '0;
    localparam logic [BYTE_W-1:0]  MIN_RESET   = '0;
    localparam logic [BYTE_W-1:0]  MAX_RESET   = 8'hFF;

    typedef struct packed {
        logic [ACC_W-1:0]   bias;
        logic [SCALE_W-1:0] scale;
        logic [BYTE_W-1:0]  zero_point;
        logic [BYTE_W-1:0]  out_min;
        logic [BYTE_W-1:0]  out_max;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] chan;
        logic              first;
        logic              last;
    } t_tap;

    typedef struct packed {
        logic              vld;
        logic [ACC_W-1:0]  acc;
        logic [BYTE_W-1:0] chan;
    } t_acc_res;

    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] chan;
    } t_pool_res;

endpackage

FILE: src/qapa_in_if.sv
interface qapa_in_if;
    logic                      valid;
    logic                      ready;
    logic [qapa_pkg::BYTE_W-1:0] tap_value;
    logic [qapa_pkg::BYTE_W-1:0] channel_index;
    logic                      first_tap;
    logic                      last_tap;

    modport source (
        output valid, tap_value, channel_index, first_tap, last_tap,
        input  ready
    );
    modport sink (
        input  valid, tap_value, channel_index, first_tap, last_tap,
        output ready
    );
endinterface

FILE: src/qapa_out_if.sv
interface qapa_out_if;
    logic                      valid;
    logic                      ready;
    logic [qapa_pkg::BYTE_W-1:0] pooled_value;
    logic [qapa_pkg::BYTE_W-1:0] out_channel;

    modport source (
        output valid, pooled_value, out_channel,
        input  ready
    );
    modport sink (
        input  valid, pooled_value, out_channel,
        output ready
    );
endinterface

FILE: src/qapa_acc.sv
module qapa_acc #(
    parameter int MAX_CHANNELS = 256,
    parameter int IDX_W        = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  qapa_pkg::t_tap                i_tap,
    input  logic [IDX_W-1:0]              i_slot,
    input  logic [qapa_pkg::ACC_W-1:0]    i_bias,
    output qapa_pkg::t_acc_res            o_res
);

    // accumulator memory, one read and one write port
    logic [qapa_pkg::ACC_W-1:0] mem [MAX_CHANNELS];
    logic [qapa_pkg::ACC_W-1:0] r_rd_data;

    logic                       r_s1_vld;
    qapa_pkg::t_tap             r_s1_tap;
    logic [IDX_W-1:0]           r_s1_slot;

    logic                       r_fw_vld;
    logic [IDX_W-1:0]           r_fw_slot;
    logic [qapa_pkg::ACC_W-1:0] r_fw_acc;

    logic                       fw_hit;
    logic [qapa_pkg::ACC_W-1:0] base;
    logic [qapa_pkg::ACC_W-1:0] n_acc;

    qapa_pkg::t_acc_res         r_res;

    // read on accept
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_rd_data <= mem[i_slot];
        end
    end

    // write back the updated sum
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            mem[r_s1_slot] <= n_acc;
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_fire;
            r_fw_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tap  <= i_tap;
        r_s1_slot <= i_slot;
        r_fw_slot <= r_s1_slot;
        r_fw_acc  <= n_acc;
    end

    // the write of the previous beat is not yet visible to this read
    assign fw_hit = r_fw_vld && (r_fw_slot == r_s1_slot);

    always_comb begin
        priority if (r_s1_tap.first) begin
            base = i_bias;
        end else if (fw_hit) begin
            base = r_fw_acc;
        end else begin
            base = r_rd_data;
        end
        n_acc = base + qapa_pkg::ACC_W'(r_s1_tap.value);
    end

    // hand the finished sum to requantization
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.vld <= 1'b0;
        end else begin
            r_res.vld <= r_s1_vld && r_s1_tap.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.acc  <= n_acc;
        r_res.chan <= r_s1_tap.chan;
    end

    assign o_res = r_res;

endmodule

FILE: src/qapa_requant.sv
module qapa_requant (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qapa_pkg::t_acc_res   i_res,
    input  qapa_pkg::t_cfg       i_cfg,
    output qapa_pkg::t_pool_res  o_res
);

    typedef struct packed {
        logic                       vld;
        logic                       neg;
        logic [qapa_pkg::ACC_W-1:0] mag;
        logic [qapa_pkg::BYTE_W-1:0] chan;
    } t_mag_stage;

    typedef struct packed {
        logic                        vld;
        logic                        neg;
        logic [qapa_pkg::PROD_W-1:0] prod;
        logic [qapa_pkg::BYTE_W-1:0] chan;
    } t_prod_stage;

    typedef struct packed {
        logic                          vld;
        logic                          neg;
        logic [qapa_pkg::QUOT_W:0]     qr;
        logic [qapa_pkg::BYTE_W-1:0]   chan;
    } t_round_stage;

    localparam logic [qapa_pkg::FRAC_W-1:0] HALF = {1'b1, {(qapa_pkg::FRAC_W-1){1'b0}}};

    t_mag_stage   r_a;
    t_prod_stage  r_b;
    t_round_stage r_c;
    qapa_pkg::t_pool_res r_d;

    logic [qapa_pkg::QUOT_W-1:0] quot;
    logic [qapa_pkg::FRAC_W-1:0] rem;
    logic                        round_up;
    logic [qapa_pkg::BYTE_W:0]   sum9;
    logic [qapa_pkg::BYTE_W-1:0] sat;
    logic [qapa_pkg::BYTE_W-1:0] lo;
    logic [qapa_pkg::BYTE_W-1:0] n_byte;

    // valid bits down the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld <= 1'b0;
            r_b.vld <= 1'b0;
            r_c.vld <= 1'b0;
            r_d.vld <= 1'b0;
        end else begin
            r_a.vld <= i_res.vld;
            r_b.vld <= r_a.vld;
            r_c.vld <= r_b.vld;
            r_d.vld <= r_c.vld;
        end
    end

    // sign and magnitude of the sum
    always_ff @(posedge i_clk) begin
        r_a.neg  <= i_res.acc[qapa_pkg::ACC_W-1];
        r_a.mag  <= i_res.acc[qapa_pkg::ACC_W-1] ? (~i_res.acc + 1'b1) : i_res.acc;
        r_a.chan <= i_res.chan;
    end

    // magnitude times scale
    always_ff @(posedge i_clk) begin
        r_b.neg  <= r_a.neg;
        r_b.prod <= qapa_pkg::PROD_W'(r_a.mag) * qapa_pkg::PROD_W'(i_cfg.scale);
        r_b.chan <= r_a.chan;
    end

    // round to nearest, ties to even
    assign quot = r_b.prod[qapa_pkg::PROD_W-1:qapa_pkg::FRAC_W];
    assign rem  = r_b.prod[qapa_pkg::FRAC_W-1:0];
    assign round_up = (rem > HALF) || ((rem == HALF) && quot[0]);

    always_ff @(posedge i_clk) begin
        r_c.neg  <= r_b.neg;
        r_c.qr   <= {1'b0, quot} + (qapa_pkg::QUOT_W + 1)'(round_up);
        r_c.chan <= r_b.chan;
    end

    // zero point, saturation and clamp
    always_comb begin
        sum9 = {1'b0, r_c.qr[qapa_pkg::BYTE_W-1:0]} + {1'b0, i_cfg.zero_point};
        if (!r_c.neg) begin
            if (r_c.qr > (qapa_pkg::QUOT_W + 1)'(8'hFF)) begin
                sat = 8'hFF;
            end else begin
                sat = sum9[qapa_pkg::BYTE_W] ? 8'hFF : sum9[qapa_pkg::BYTE_W-1:0];
            end
        end else begin
            if (r_c.qr > (qapa_pkg::QUOT_W + 1)'(i_cfg.zero_point)) begin
                sat = '0;
            end else begin
                sat = i_cfg.zero_point - r_c.qr[qapa_pkg::BYTE_W-1:0];
            end
        end
        lo     = (sat < i_cfg.out_min) ? i_cfg.out_min : sat;
        n_byte = (lo > i_cfg.out_max) ? i_cfg.out_max : lo;
    end

    always_ff @(posedge i_clk) begin
        r_d.value <= n_byte;
        r_d.chan  <= r_c.chan;
    end

    assign o_res = r_d;

endmodule

FILE: src/quantized_average_pool_accumulate.sv
// Average pooling accumulator with requantization. Each input beat adds one
// byte into a per-channel 32-bit accumulator held in a single-port-read,
// single-port-write memory; a first-tap beat loads bias plus the byte. One
// beat is taken every cycle while input ready is high, including back-to-back
// beats on the same channel, which a one-deep forward path covers. On its way
// to the output a last-tap beat passes memory read, sum, sign split, 32x32
// multiply by the Q8.24 scale, round half to even, zero point with saturation
// and min/max clamp, then the write into an 8-entry output queue; input ready
// falls only while eight results are owed to the sink. Channels at or above
// MAX_CHANNELS share accumulators modulo MAX_CHANNELS. Configuration must be
// written only while no beats are in flight; the block itself does not enforce
// this. Accumulators hold no defined value after reset until a first-tap beat
// loads them.
module quantized_average_pool_accumulate #(
    parameter int MAX_CHANNELS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [qapa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [qapa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    qapa_in_if.sink                            i_in,
    qapa_out_if.source                         o_out
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    typedef logic [IDX_W-1:0] t_slot_tab [qapa_pkg::CHAN_CNT];

    function automatic t_slot_tab f_slot_tab();
        t_slot_tab tab;
        for (int i = 0; i < qapa_pkg::CHAN_CNT; i++) begin
            tab[i] = IDX_W'(i % MAX_CHANNELS);
        end
        return tab;
    endfunction

    localparam t_slot_tab SLOT_TAB = f_slot_tab();

    qapa_pkg::t_cfg      r_cfg;
    qapa_pkg::t_tap      tap;
    qapa_pkg::t_acc_res  acc_res;
    qapa_pkg::t_pool_res pool_res;

    logic                in_fire;
    logic                out_fire;
    logic [IDX_W-1:0]    slot;

    logic [qapa_pkg::OUT_Q_CNT_W-1:0] r_owed;
    logic [qapa_pkg::OUT_Q_CNT_W-1:0] r_q_cnt;
    logic [qapa_pkg::OUT_Q_PTR_W-1:0] r_wr_ptr;
    logic [qapa_pkg::OUT_Q_PTR_W-1:0] r_rd_ptr;
    logic [qapa_pkg::BYTE_W-1:0]      r_q_value [qapa_pkg::OUT_Q_DEPTH];
    logic [qapa_pkg::BYTE_W-1:0]      r_q_chan  [qapa_pkg::OUT_Q_DEPTH];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bias       <= qapa_pkg::BIAS_RESET;
            r_cfg.scale      <= qapa_pkg::SCALE_RESET;
            r_cfg.zero_point <= qapa_pkg::ZP_RESET;
            r_cfg.out_min    <= qapa_pkg::MIN_RESET;
            r_cfg.out_max    <= qapa_pkg::MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (qapa_pkg::t_cfg_idx'(i_cfg_idx))
                qapa_pkg::CFG_ACC_BIAS: begin
                    r_cfg.bias <= i_cfg_data[qapa_pkg::ACC_W-1:0];
                end
                qapa_pkg::CFG_SCALE: begin
                    r_cfg.scale <= i_cfg_data[qapa_pkg::SCALE_W-1:0];
                end
                qapa_pkg::CFG_ZERO_POINT: begin
                    r_cfg.zero_point <= i_cfg_data[qapa_pkg::BYTE_W-1:0];
                end
                qapa_pkg::CFG_OUT_MIN: begin
                    r_cfg.out_min <= i_cfg_data[qapa_pkg::BYTE_W-1:0];
                end
                qapa_pkg::CFG_OUT_MAX: begin
                    r_cfg.out_max <= i_cfg_data[qapa_pkg::BYTE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input side
    assign i_in.ready = (r_owed < qapa_pkg::OUT_Q_CNT_W'(qapa_pkg::OUT_Q_DEPTH));
    assign in_fire    = i_in.valid && i_in.ready;
    assign slot       = SLOT_TAB[i_in.channel_index];

    assign tap.value = i_in.tap_value;
    assign tap.chan  = i_in.channel_index;
    assign tap.first = i_in.first_tap;
    assign tap.last  = i_in.last_tap;

    qapa_acc #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_tap   (tap),
        .i_slot  (slot),
        .i_bias  (r_cfg.bias),
        .o_res   (acc_res)
    );

    qapa_requant u_requant (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (acc_res),
        .i_cfg   (r_cfg),
        .o_res   (pool_res)
    );

    // results owed to the sink, counted from acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed <= '0;
        end else begin
            r_owed <= r_owed + qapa_pkg::OUT_Q_CNT_W'(in_fire && i_in.last_tap)
                      - qapa_pkg::OUT_Q_CNT_W'(out_fire);
        end
    end

    // output queue
    assign out_fire = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            if (pool_res.vld) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_q_cnt <= r_q_cnt + qapa_pkg::OUT_Q_CNT_W'(pool_res.vld)
                       - qapa_pkg::OUT_Q_CNT_W'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pool_res.vld) begin
            r_q_value[r_wr_ptr] <= pool_res.value;
            r_q_chan[r_wr_ptr]  <= pool_res.chan;
        end
    end

    assign o_out.valid        = (r_q_cnt != '0);
    assign o_out.pooled_value = r_q_value[r_rd_ptr];
    assign o_out.out_channel  = r_q_chan[r_rd_ptr];

endmodule

FILE: src/qapa_checker.sv
`include "quantized_average_pool_accumulate_macros.svh"

module qapa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_last,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [qapa_pkg::BYTE_W-1:0] i_out_value,
    input logic [qapa_pkg::BYTE_W-1:0] i_out_channel
);

    logic                            in_last_fire;
    logic                            out_fire;
    logic                            out_stall;
    logic [2*qapa_pkg::BYTE_W-1:0]   out_beat;
    logic [4:0]                      r_pend;

    assign in_last_fire = i_in_valid && i_in_ready && i_in_last;
    assign out_fire     = i_out_valid && i_out_ready;
    assign out_stall    = i_out_valid && !i_out_ready;
    assign out_beat     = {i_out_value, i_out_channel};

    // last-tap beats accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 5'(in_last_fire) - 5'(out_fire);
        end
    end

    // a stalled result holds
    `QAPA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_beat))

    // no result without a last tap before it
    `QAPA_ASSERT_NOW(a_out_owed, i_clk, i_rst_n, i_out_valid, r_pend != 5'd0)

    // input stalls only while results are owed
    `QAPA_ASSERT_NOW(a_ready_owed, i_clk, i_rst_n, !i_in_ready, r_pend != 5'd0)

    // fixed latency through an empty pipe
    `QAPA_ASSERT_NOW(a_latency, i_clk, i_rst_n, in_last_fire && (r_pend == 5'd0), ##7 i_out_valid)

endmodule

bind quantized_average_pool_accumulate qapa_checker u_qapa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_last     (i_in.last_tap),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_value   (o_out.pooled_value),
    .i_out_channel (o_out.out_channel)
);

FILE: verif/pool_result_checker.sv
`timescale 1ns / 100ps

module pool_result_checker
    import qapa_pkg::*;
#(
    parameter int MAX_CHANNELS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    qapa_in_if                    i_taps,
    qapa_out_if                   i_pooled,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam logic [FRAC_W-1:0] HALF_LSB = {1'b1, {(FRAC_W-1){1'b0}}};

    typedef struct packed {
        logic [BYTE_W-1:0] pooled;
        logic [BYTE_W-1:0] chan;
    } t_pooled_beat;

    // shadow of the configuration registers
    logic [ACC_W-1:0]   bias_q;
    logic [SCALE_W-1:0] scale_q;
    logic [BYTE_W-1:0]  zero_point_q;
    logic [BYTE_W-1:0]  floor_q;
    logic [BYTE_W-1:0]  ceiling_q;

    logic [ACC_W-1:0] channel_sums [MAX_CHANNELS];
    t_pooled_beat     owed_results [$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] pool mismatch: %s", $realtime, what);
        o_mismatches++;
    endtask

    // signed sum times Q8.24 scale, round half to even, zero point, saturate, clamp
    function automatic logic [BYTE_W-1:0] requantize(input logic [ACC_W-1:0] sum);
        logic              neg;
        logic [ACC_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        logic [FRAC_W-1:0] frac;
        longint            level;
        logic [BYTE_W-1:0] byte_out;
        neg  = sum[ACC_W-1];
        mag  = neg ? (~sum + 1'b1) : sum;
        prod = PROD_W'(mag) * PROD_W'(scale_q);
        quot = prod[PROD_W-1:FRAC_W];
        frac = prod[FRAC_W-1:0];
        if (frac > HALF_LSB || (frac == HALF_LSB && quot[0])) begin
            quot = quot + 1'b1;
        end
        level = neg ? -longint'(quot) : longint'(quot);
        level = level + longint'(zero_point_q);
        if (level < 0) begin
            level = 0;
        end
        if (level > 255) begin
            level = 255;
        end
        byte_out = level[BYTE_W-1:0];
        if (byte_out < floor_q) begin
            byte_out = floor_q;
        end
        if (byte_out > ceiling_q) begin
            byte_out = ceiling_q;
        end
        return byte_out;
    endfunction

    always @(posedge i_clk) begin
        int               slot;
        logic [ACC_W-1:0] sum;
        t_pooled_beat     want;
        if (!i_rst_n) begin
            bias_q       = BIAS_RESET;
            scale_q      = SCALE_RESET;
            zero_point_q = ZP_RESET;
            floor_q      = MIN_RESET;
            ceiling_q    = MAX_RESET;
            owed_results.delete();
        end else begin
            // output beat against the oldest owed result
            if (i_pooled.valid && i_pooled.ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("beat on channel %0d with nothing owed",
                                              i_pooled.out_channel));
                end else begin
                    want = owed_results.pop_front();
                    if (i_pooled.pooled_value !== want.pooled) begin
                        report_mismatch($sformatf("channel %0d value %0d, want %0d",
                                                  want.chan, i_pooled.pooled_value,
                                                  want.pooled));
                    end
                    if (i_pooled.out_channel !== want.chan) begin
                        report_mismatch($sformatf("channel %0d, want %0d",
                                                  i_pooled.out_channel, want.chan));
                    end
                end
            end

            // input beat updates the channel sum, last tap owes a result
            if (i_taps.valid && i_taps.ready) begin
                slot = int'(i_taps.channel_index) % MAX_CHANNELS;
                sum  = (i_taps.first_tap ? bias_q : channel_sums[slot])
                       + ACC_W'(i_taps.tap_value);
                channel_sums[slot] = sum;
                if (i_taps.last_tap) begin
                    want.pooled = requantize(sum);
                    want.chan   = i_taps.channel_index;
                    owed_results.push_back(want);
                end
            end

            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ACC_BIAS:   bias_q       = i_cfg_data[ACC_W-1:0];
                    CFG_SCALE:      scale_q      = i_cfg_data[SCALE_W-1:0];
                    CFG_ZERO_POINT: zero_point_q = i_cfg_data[BYTE_W-1:0];
                    CFG_OUT_MIN:    floor_q      = i_cfg_data[BYTE_W-1:0];
                    CFG_OUT_MAX:    ceiling_q    = i_cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = owed_results.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import qapa_pkg::*;

    localparam int MAX_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD = 150;

    typedef enum {SINK_OPEN, SINK_BUSY, SINK_CHOKED, SINK_PERIODIC} t_sink_mode;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int cycle_count = 0;

    // sender and sink pacing
    int         burst_left = 0;
    bit         no_gaps = 1'b0;
    bit         long_hold_req = 1'b0;
    int         hold_left = 0;
    t_sink_mode sink_mode = SINK_OPEN;
    int         sink_mode_left = 0;
    int         sink_cycle = 0;

    // pooling windows in progress
    bit chan_loaded [CHAN_CNT];
    int open_chans [$];
    int open_left [$];

    qapa_in_if  tap_ch ();
    qapa_out_if pool_ch ();

    quantized_average_pool_accumulate #(
        .MAX_CHANNELS(CHAN_CNT)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (tap_ch),
        .o_out      (pool_ch)
    );

    pool_result_checker #(
        .MAX_CHANNELS(CHAN_CNT)
    ) result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_taps       (tap_ch),
        .i_pooled     (pool_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("[quantized_average_pool_accumulate] ERROR");
            $finish;
        end
    end

    // sink ready: long hold on request, otherwise a changing pattern
    always @(negedge clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (sink_mode_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            sink_mode_left = $urandom_range(32, 256);
        end
        sink_mode_left--;
        sink_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            pool_ch.ready <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_OPEN:     pool_ch.ready <= 1'b1;
                SINK_BUSY:     pool_ch.ready <= ($urandom_range(0, 3) != 0);
                SINK_CHOKED:   pool_ch.ready <= ($urandom_range(0, 3) == 0);
                SINK_PERIODIC: pool_ch.ready <= (sink_cycle % 5 != 0);
                default:       pool_ch.ready <= 1'b1;
            endcase
        end
    end

    // one tap beat, sent in bursts with random gaps between them
    task automatic send_tap(input logic [BYTE_W-1:0] value, input logic [BYTE_W-1:0] chan,
                            input logic first, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                tap_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        tap_ch.valid         <= 1'b1;
        tap_ch.tap_value     <= value;
        tap_ch.channel_index <= chan;
        tap_ch.first_tap     <= first;
        tap_ch.last_tap      <= last;
        if (first) begin
            chan_loaded[chan] = 1'b1;
        end
        do @(posedge clk); while (!tap_ch.ready);
        @(negedge clk);
    endtask

    // stop sending, wait for owed results and the pipeline tail
    task automatic wait_idle();
        tap_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_config(input logic [ACC_W-1:0] bias, input logic [SCALE_W-1:0] scale,
                                input logic [BYTE_W-1:0] zero_point,
                                input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
        t_cfg_idx              regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        regs = '{CFG_ACC_BIAS, CFG_SCALE, CFG_ZERO_POINT, CFG_OUT_MIN, CFG_OUT_MAX};
        vals = '{bias, scale, CFG_DATA_W'(zero_point), CFG_DATA_W'(lo), CFG_DATA_W'(hi)};
        wait_idle();
        for (int i = 0; i < 5; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= regs[i];
            cfg_data <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        logic [ACC_W-1:0]   bias;
        logic [SCALE_W-1:0] scale;
        logic [BYTE_W-1:0]  zero_point;
        logic [BYTE_W-1:0]  a;
        logic [BYTE_W-1:0]  b;
        case ($urandom_range(0, 5))
            0:       bias = 32'h8000_0000;
            1:       bias = 32'h7FFF_FFFF;
            2:       bias = '0;
            3:       bias = -($urandom_range(0, 255) * $urandom_range(1, 9));
            default: bias = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0:       scale = '0;
            1:       scale = 32'hFFFF_FFFF;
            2:       scale = 32'h0080_0000;
            3:       scale = $urandom;
            default: scale = $urandom_range(32'h0010_0000, 32'h0200_0000);
        endcase
        zero_point = BYTE_W'($urandom_range(0, 255));
        a = BYTE_W'($urandom_range(0, 255));
        b = BYTE_W'($urandom_range(0, 255));
        // bounds crossed now and then
        if ($urandom_range(0, 3) == 0 || a <= b) begin
            apply_config(bias, scale, zero_point, a, b);
        end else begin
            apply_config(bias, scale, zero_point, b, a);
        end
    endtask

    // mostly well formed windows over a few interleaved channels, some noise
    task automatic send_random_item();
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] chan;
        logic              first;
        logic              last;
        int                taps;
        int                k;
        bit                busy;
        case ($urandom_range(0, 9))
            0:       value = '0;
            1:       value = 8'hFF;
            default: value = BYTE_W'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 99) < 15) begin
            chan  = BYTE_W'($urandom_range(0, 255));
            first = 1'($urandom_range(0, 1));
            last  = 1'($urandom_range(0, 1));
            if (!chan_loaded[chan]) begin
                first = 1'b1;
            end
        end else if (open_chans.size() < 4 && (open_chans.size() == 0
                                               || $urandom_range(0, 2) == 0)) begin
            // open a new window on a channel not already in use
            do begin
                chan = BYTE_W'($urandom_range(0, 255));
                busy = 1'b0;
                foreach (open_chans[j]) begin
                    if (open_chans[j] == chan) begin
                        busy = 1'b1;
                    end
                end
            end while (busy);
            taps  = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
            first = 1'b1;
            last  = (taps == 1);
            if (taps > 1) begin
                open_chans.push_back(int'(chan));
                open_left.push_back(taps - 1);
            end
        end else begin
            // next tap of an open window
            k = $urandom_range(0, open_chans.size() - 1);
            chan = BYTE_W'(open_chans[k]);
            open_left[k]--;
            first = 1'b0;
            last  = (open_left[k] == 0);
            if (last) begin
                open_chans.delete(k);
                open_left.delete(k);
            end
        end
        send_tap(value, chan, first, last);
    endtask

    // sink holds off while single-tap windows keep coming back to back
    task automatic squeeze_run(input int count);
        no_gaps = 1'b1;
        burst_left = 0;
        long_hold_req = 1'b1;
        repeat (count) begin
            send_tap(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                     1'b1, 1'b1);
        end
        no_gaps = 1'b0;
        burst_left = 0;
    endtask

    initial begin
        tap_ch.valid         = 1'b0;
        tap_ch.tap_value     = '0;
        tap_ch.channel_index = '0;
        tap_ch.first_tap     = 1'b0;
        tap_ch.last_tap      = 1'b0;
        pool_ch.ready        = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_ACC_BIAS;
        cfg_data             = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: byte extremes, single-tap windows, last tap on a loaded channel, a three-tap window
        send_tap(8'h00, 8'd0, 1'b1, 1'b1);
        send_tap(8'hFF, 8'd255, 1'b1, 1'b1);
        send_tap(8'h07, 8'd0, 1'b0, 1'b1);
        send_tap(8'hFF, 8'd5, 1'b1, 1'b0);
        send_tap(8'h80, 8'd5, 1'b0, 1'b0);
        send_tap(8'h01, 8'd5, 1'b0, 1'b1);

        // half scale: rounding ties both ways, positive and negative
        apply_config(-32'sd3, 32'h0080_0000, 8'd10, 8'd0, 8'd255);
        send_tap(8'd4, 8'd1, 1'b1, 1'b1);
        send_tap(8'd6, 8'd2, 1'b1, 1'b1);
        send_tap(8'd0, 8'd3, 1'b1, 1'b1);
        send_tap(8'd2, 8'd4, 1'b1, 1'b1);

        // sum wraps past the top, largest scale, crossed bounds
        apply_config(32'h7FFF_FF80, 32'hFFFF_FFFF, 8'd255, 8'd200, 8'd100);
        send_tap(8'hFF, 8'd6, 1'b1, 1'b0);
        send_tap(8'hFF, 8'd6, 1'b0, 1'b1);
        send_tap(8'd100, 8'd7, 1'b1, 1'b1);

        // most negative bias, smallest nonzero scale
        apply_config(32'h8000_0000, 32'h0000_0001, 8'd128, 8'd0, 8'd255);
        send_tap(8'hFF, 8'd8, 1'b1, 1'b1);
        send_tap(8'h00, 8'd9, 1'b1, 1'b1);

        // random settings and windows
        for (int phase = 0; phase < 8; phase++) begin
            random_config();
            if (phase == 2 || phase == 5) begin
                squeeze_run(40);
            end
            repeat (120) send_random_item();
        end

        wait_idle();
        if (mismatches == 0 && pending == 0) begin
            $display("[quantized_average_pool_accumulate] OK");
        end else begin
            $display("[quantized_average_pool_accumulate] ERROR");
        end
        $finish;
    end

endmodule
